@@ sv/stwq_pkg.sv @@
package stwq_pkg;

	localparam int DEPTH     = 16;
	localparam int TASK_BITS = 8;
	localparam int OCC_W     = $clog2(DEPTH + 1);
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int TIME_W    = 32;
	localparam int TASK_W    = 8;

	// command carried in the input tuser
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_SLEEP = 1'b1;

	// result kinds carried in the output tuser
	localparam logic [1:0] KIND_SLEEP = 2'd0;
	localparam logic [1:0] KIND_WAKE  = 2'd1;
	localparam logic [1:0] KIND_IDLE  = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0]    wake;
		logic [TASK_BITS-1:0] task_id;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t ent;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

endpackage

@@ sv/sorted_timeout_wake_queue_unit.sv @@
// Sorted timer queue. A row of DEPTH cells holds sleeping task ids in
// ascending wake-time order; every cell compares its own wake time with an
// incoming one, so a sleep word is inserted without a search and, when the
// result word is taken at once, sleep words flow back to back. A tick word
// bumps the tick counter in its accept cycle and then drains due entries from
// the head of the row, one result word per cycle while results are taken,
// so a tick gives max(1, n) result words where n is the number of tasks
// woken; the row shifts left one cell per pop. Wake times are plain
// unsigned 32-bit sums (counter + delay, wrapping) compared without any wrap
// allowance. A sleep arriving with the row full is refused with queue_full.
// Results sit in an output register, and while idle the next input word is
// taken in the same cycle the pending result is taken.
module sorted_timeout_wake_queue_unit import stwq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [7:0] task_id, [39:8] delay
	input  logic [0:0]  s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] woken_task, [39:8] tick_now, [40] queue_full
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);

	state_t            st_q, st_d;
	logic [TIME_W-1:0] counter_q;
	logic [OCC_W-1:0]  occ_q;

	// output register
	logic              m_valid_q;
	logic [1:0]        m_kind_q;
	logic [TASK_W-1:0] m_task_q;
	logic [TIME_W-1:0] m_now_q;
	logic              m_full_q;
	logic              m_last_q;

	logic              out_free, s_acc, is_sleep, is_full;
	logic              out_load, head_due, next_due;
	logic [1:0]        out_kind;
	logic [TASK_W-1:0] out_task;
	logic              out_full, out_last;
	logic              tick_acc;
	cell_ctl_t         ctl;

	entry_t            ent  [DEPTH];
	logic              lt   [DEPTH];
	logic              occ  [DEPTH];

	assign out_free = !m_valid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;
	assign is_sleep = (s_tuser[0] == CMD_SLEEP);
	assign is_full  = (occ_q == OCC_W'(DEPTH));

	// head of the row against the already incremented counter
	assign head_due = (occ_q != '0) && (ent[0].wake <= counter_q);
	assign next_due = (occ_q > OCC_W'(1)) && (ent[1].wake <= counter_q);

	// ---------------------------------------------------------------------
	// cell row
	// ---------------------------------------------------------------------
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			assign occ[gi] = (OCC_W'(gi) < occ_q);
			stwq_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.occupied (occ[gi]),
				.prev_lt  ((gi == 0) ? 1'b1 : lt[(gi == 0) ? 0 : gi - 1]),
				.prev_ent ((gi == 0) ? ctl.ent : ent[(gi == 0) ? 0 : gi - 1]),
				.next_ent ((gi == DEPTH - 1) ? ent[gi] : ent[(gi == DEPTH - 1) ? gi : gi + 1]),
				.ent      (ent[gi]),
				.lt       (lt[gi])
			);
		end
	endgenerate

	// ---------------------------------------------------------------------
	// control
	// ---------------------------------------------------------------------
	always_comb begin
		st_d     = st_q;
		s_tready = 1'b0;
		// new entry: wake = counter + delay, mod 2^32
		ctl.ent.wake    = counter_q + s_tdata[39:8];
		ctl.ent.task_id = s_tdata[TASK_BITS-1:0];
		ctl.ins  = 1'b0;
		ctl.pop  = 1'b0;
		out_load = 1'b0;
		out_kind = KIND_SLEEP;
		out_task = '0;
		out_full = 1'b0;
		out_last = 1'b1;
		tick_acc = 1'b0;
		case (st_q)
			ST_IDLE: begin
				s_tready = out_free;
				if (s_acc) begin
					if (is_sleep) begin
						out_load = 1'b1;
						out_full = is_full;
						ctl.ins  = !is_full;
					end else begin
						tick_acc = 1'b1;
						st_d     = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					out_load = 1'b1;
					if (head_due) begin
						// wake one task; last if the next one is not due
						out_kind = KIND_WAKE;
						out_task = TASK_W'(ent[0].task_id);
						out_last = !next_due;
						ctl.pop  = 1'b1;
						if (!next_due) begin
							st_d = ST_IDLE;
						end
					end else begin
						// only reached on the first step: nothing due
						out_kind = KIND_IDLE;
						st_d     = ST_IDLE;
					end
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			counter_q <= '0;
			occ_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (tick_acc) begin
				counter_q <= counter_q + TIME_W'(1);
			end
			if (ctl.ins) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (ctl.pop) begin
				occ_q <= occ_q - OCC_W'(1);
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_kind_q <= out_kind;
			m_task_q <= out_task;
			m_now_q  <= counter_q;
			m_full_q <= out_full;
			m_last_q <= out_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {7'd0, m_full_q, m_now_q, m_task_q};

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("occupancy beyond row depth");

	a_drain_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DRAIN |-> !s_tready)
		else $error("input taken while draining");

	a_full_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && is_sleep && is_full |=> occ_q == $past(occ_q))
		else $error("refused sleep changed occupancy");

	a_pop_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |=> occ_q == $past(occ_q) - OCC_W'(1))
		else $error("pop did not remove exactly one entry");

	a_wake_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> occ_q != '0)
		else $error("pop from empty row");

endmodule

@@ sv/stwq_cell.sv @@
module stwq_cell import stwq_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  logic      prev_lt,
	input  entry_t    prev_ent,
	input  entry_t    next_ent,
	output entry_t    ent,
	output logic      lt
);

	entry_t ent_q;

	// entries before the insert point all compare lower (sorted row)
	assign lt  = occupied && (ent_q.wake < ctl.ent.wake);
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!prev_lt) begin
				ent_q <= prev_ent;
			end else if (!lt) begin
				ent_q <= ctl.ent;
			end
		end else if (ctl.pop) begin
			ent_q <= next_ent;
		end
	end

endmodule
